[design/svft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svft_pkg - sorted value frequency table shared definitions
// Widths, limits and the entry and control types used by the cell row.
// ----------------------------------------------------------------------------
package svft_pkg;

    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int TABLE_ENTRIES_D = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
    } t_entry;

    typedef struct packed {
        logic tally;
        logic hit;
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

[design/svft_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svft_if - request channels of the sorted value frequency table
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface svft_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [svft_pkg::VALUE_W-1:0] sample_value;
    logic                               set_end;

    modport source (output valid, output sample_value, output set_end, input ready);
    modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface

interface svft_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [svft_pkg::VALUE_W-1:0] distinct_value;
    logic [svft_pkg::COUNT_W-1:0]       occurrences;
    logic                               run_last;
    logic                               table_overflowed;

    modport source (output valid, output distinct_value, output occurrences,
                    output run_last, output table_overflowed, input ready);
    modport sink   (input valid, input distinct_value, input occurrences,
                    input run_last, input table_overflowed, output ready);
endinterface

[design/svft_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svft_cell - one slot of the sorted table
// Holds one value and its count, compares against the broadcast sample and
// takes the sample, its left neighbor or its right neighbor as directed.
// ----------------------------------------------------------------------------
module svft_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  svft_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [svft_pkg::VALUE_W-1:0] i_sample,
    input  svft_pkg::t_entry                    i_left,
    input  logic                                i_left_gt,
    input  svft_pkg::t_entry                    i_right,
    output svft_pkg::t_entry                    o_entry,
    output logic                                o_gt,
    output logic                                o_eq
);

    svft_pkg::t_entry r_entry;
    svft_pkg::t_entry n_entry;

    assign o_gt    = !r_entry.valid || (r_entry.value > i_sample);
    assign o_eq    = r_entry.valid && (r_entry.value == i_sample);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.drain) begin
            n_entry = i_right;
        end else if (i_ctrl.tally) begin
            if (i_ctrl.hit) begin
                if (o_eq && (r_entry.count != svft_pkg::COUNT_MAX)) begin
                    n_entry.count = r_entry.count + svft_pkg::COUNT_ONE;
                end
            end else if (i_ctrl.insert && o_gt) begin
                if (i_left_gt) begin
                    n_entry = i_left;
                end else begin
                    n_entry.valid = 1'b1;
                    n_entry.value = i_sample;
                    n_entry.count = svft_pkg::COUNT_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

[design/sorted_value_frequency_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_frequency_table - sorted histogram of distinct values
// Counts signed samples in a row of sorted cells and streams out the
// distinct values in ascending order with their counts at the end of a set.
// ----------------------------------------------------------------------------
// A sample request is taken every cycle while a set is being counted: all
// cells compare it at once and either bump a count or open a slot in sorted
// position by shifting the larger entries one cell to the right. The request
// flagged as set end is counted the same way, then the sample side stalls
// while the row shifts out toward cell zero, one result per cycle while the
// result side is ready, and the next sample is taken only after the last
// result of the set is taken. Counts stop at 65535; a new value that finds
// all TABLE_ENTRIES cells full is dropped and flagged on every result of
// that set. The row is empty again after its last result is taken.
module sorted_value_frequency_table #(
    parameter int TABLE_ENTRIES = svft_pkg::TABLE_ENTRIES_D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    svft_sample_if.sink          i_sample,
    svft_result_if.source        o_result
);

    svft_pkg::t_entry     w_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_gt;
    logic [TABLE_ENTRIES-1:0] w_eq;
    svft_pkg::t_cell_ctrl w_ctrl;

    logic r_readout;
    logic n_readout;
    logic r_overflow;
    logic n_overflow;
    logic w_in_acc;
    logic w_out_acc;
    logic w_full;

    assign w_in_acc  = i_sample.valid && i_sample.ready;
    assign w_out_acc = o_result.valid && o_result.ready;
    assign w_full    = w_entry[TABLE_ENTRIES-1].valid;

    assign w_ctrl.tally  = w_in_acc;
    assign w_ctrl.hit    = |w_eq;
    assign w_ctrl.insert = !w_full;
    assign w_ctrl.drain  = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            svft_pkg::t_entry w_left;
            svft_pkg::t_entry w_right;
            logic             w_left_gt;

            if (g == 0) begin : g_head
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_left_gt = w_gt[g-1];
            end

            if (g == TABLE_ENTRIES - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end

            svft_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_sample  (i_sample.sample_value),
                .i_left    (w_left),
                .i_left_gt (w_left_gt),
                .i_right   (w_right),
                .o_entry   (w_entry[g]),
                .o_gt      (w_gt[g]),
                .o_eq      (w_eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_readout  = r_readout;
        n_overflow = r_overflow;
        if (w_in_acc) begin
            if (!w_ctrl.hit && w_full) begin
                n_overflow = 1'b1;
            end
            if (i_sample.set_end) begin
                n_readout = 1'b1;
            end
        end
        if (w_out_acc && o_result.run_last) begin
            n_readout  = 1'b0;
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readout  <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_readout  <= n_readout;
            r_overflow <= n_overflow;
        end
    end

    assign i_sample.ready            = !r_readout;
    assign o_result.valid            = r_readout;
    assign o_result.distinct_value   = w_entry[0].value;
    assign o_result.occurrences      = w_entry[0].count;
    assign o_result.run_last         = !w_entry[1].valid;
    assign o_result.table_overflowed = r_overflow;

endmodule

[bench/sorted_value_frequency_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_frequency_table_tb - self-checking bench for the value table
// Streams sets of signed samples into the table with random gaps and result
// backpressure. It predicts each sorted readout and checks every result
// field. Covers: extreme values, duplicates, single-sample sets, exactly full
// tables, overflow with the set end on a dropped value, long runs of one
// value, and random sets of mixed size.
// ----------------------------------------------------------------------------
module sorted_value_frequency_table_tb;

    localparam logic signed [svft_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [svft_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 155;

    typedef struct {
        logic signed [svft_pkg::VALUE_W-1:0] value;
        logic                                fin;
    } t_sample_req;

    typedef struct {
        logic signed [svft_pkg::VALUE_W-1:0] value;
        logic [svft_pkg::COUNT_W-1:0]        count;
        logic                                last;
        logic                                dropped;
    } t_tally_row;

    logic i_clk;
    logic i_rst_n;

    svft_sample_if sample_ch ();
    svft_result_if result_ch ();

    sorted_value_frequency_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch)
    );

    t_sample_req pending_samples[$];
    t_tally_row  expected_pairs[$];

    logic signed [svft_pkg::VALUE_W-1:0] seen_values[svft_pkg::TABLE_ENTRIES_D];
    logic [svft_pkg::COUNT_W-1:0]        seen_counts[svft_pkg::TABLE_ENTRIES_D];
    int                                  seen_total = 0;
    logic                                value_dropped = 1'b0;

    int mismatches  = 0;
    int cycle_no    = 0;
    int idle_cycles = 0;
    logic run_done  = 1'b0;
    logic steady;

    assign steady = (cycle_no >= 300) && (cycle_no < 500);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count one sample; on set end, sort the table and queue its readout.
    function automatic void tally_sample(logic signed [svft_pkg::VALUE_W-1:0] v, logic fin);
        int slot;
        int k;
        int j;
        logic signed [svft_pkg::VALUE_W-1:0] hold_v;
        logic [svft_pkg::COUNT_W-1:0]        hold_c;
        t_tally_row row;
        slot = -1;
        for (k = 0; k < seen_total; k++) begin
            if (seen_values[k] == v) slot = k;
        end
        if (slot >= 0) begin
            if (seen_counts[slot] != svft_pkg::COUNT_MAX)
                seen_counts[slot] = seen_counts[slot] + svft_pkg::COUNT_ONE;
        end else if (seen_total < svft_pkg::TABLE_ENTRIES_D) begin
            seen_values[seen_total] = v;
            seen_counts[seen_total] = svft_pkg::COUNT_ONE;
            seen_total++;
        end else begin
            value_dropped = 1'b1;
        end
        if (fin) begin
            for (k = 1; k < seen_total; k++) begin
                hold_v = seen_values[k];
                hold_c = seen_counts[k];
                j = k;
                while (j > 0 && seen_values[j-1] > hold_v) begin
                    seen_values[j] = seen_values[j-1];
                    seen_counts[j] = seen_counts[j-1];
                    j--;
                end
                seen_values[j] = hold_v;
                seen_counts[j] = hold_c;
            end
            for (k = 0; k < seen_total; k++) begin
                row.value   = seen_values[k];
                row.count   = seen_counts[k];
                row.last    = (k == seen_total - 1);
                row.dropped = value_dropped;
                expected_pairs.push_back(row);
            end
            seen_total    = 0;
            value_dropped = 1'b0;
        end
    endfunction

    task automatic queue_sample(logic signed [svft_pkg::VALUE_W-1:0] v, logic fin);
        t_sample_req req;
        req.value = v;
        req.fin   = fin;
        pending_samples.push_back(req);
    endtask

    // Sample driver: hold the request until taken, then advance.
    always @(posedge i_clk) begin
        t_sample_req req;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready)
                tally_sample(sample_ch.sample_value, sample_ch.set_end);
            if (!sample_ch.valid || sample_ch.ready) begin
                if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
                    req = pending_samples.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.sample_value <= req.value;
                    sample_ch.set_end      <= req.fin;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge i_clk) begin
        t_tally_row want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("distinct_value: expected none, got %0d", result_ch.distinct_value);
                    mismatches++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (result_ch.distinct_value !== want.value) begin
                        $error("distinct_value: expected %0d, got %0d",
                               want.value, result_ch.distinct_value);
                        mismatches++;
                    end
                    if (result_ch.occurrences !== want.count) begin
                        $error("occurrences: expected %0d, got %0d",
                               want.count, result_ch.occurrences);
                        mismatches++;
                    end
                    if (result_ch.run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.last, result_ch.run_last);
                        mismatches++;
                    end
                    if (result_ch.table_overflowed !== want.dropped) begin
                        $error("table_overflowed: expected %0b, got %0b",
                               want.dropped, result_ch.table_overflowed);
                        mismatches++;
                    end
                end
            end
            result_ch.ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (i_rst_n && !run_done) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** sorted_value_frequency_table: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int set_len;
        int made;
        logic signed [svft_pkg::VALUE_W-1:0] pool[6];
        logic signed [svft_pkg::VALUE_W-1:0] v;

        i_rst_n                = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.set_end      = 1'b0;
        result_ch.ready        = 1'b0;

        // extremes with duplicates
        queue_sample(VAL_MIN, 1'b0);
        queue_sample(VAL_MAX, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(VAL_MAX, 1'b0);
        queue_sample(VAL_MIN, 1'b0);
        queue_sample(-1, 1'b1);
        // single-sample set
        queue_sample(5, 1'b1);
        // alternating bit patterns
        queue_sample(32'sh5555_5555, 1'b0);
        queue_sample(32'shAAAA_AAAA, 1'b0);
        queue_sample(32'sh5555_5555, 1'b1);
        // descending run
        for (k = 0; k < 10; k++) queue_sample(300 - k * 67, k == 9);

        // exactly full table, set end on a stored value
        for (k = 0; k < svft_pkg::TABLE_ENTRIES_D; k++)
            queue_sample((k % 2) ? -k * 1000 : k * 1000003, 1'b0);
        queue_sample(5 * 1000003 - 5 * 1000003 + (-5 * 1000), 1'b1);

        // overflow, set end on a dropped value
        for (k = svft_pkg::TABLE_ENTRIES_D - 1; k >= 0; k--) queue_sample(k * 13 - 400, 1'b0);
        queue_sample(VAL_MAX, 1'b0);
        queue_sample(VAL_MIN, 1'b0);
        queue_sample(99999, 1'b1);

        // long run of one value
        for (k = 0; k < 20; k++) queue_sample(7, 1'b0);
        queue_sample(-8, 1'b0);
        queue_sample(7, 1'b1);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            for (k = 0; k < 6; k++) pool[k] = $urandom;
            if ($urandom_range(9) == 0) begin
                set_len = $urandom_range(80, 60);
                for (k = 0; k < set_len; k++) begin
                    v = ($urandom_range(7) == 0) ? pool[$urandom_range(5)] : $urandom;
                    queue_sample(v, k == set_len - 1);
                end
            end else begin
                set_len = $urandom_range(24, 1);
                for (k = 0; k < set_len; k++) begin
                    case ($urandom_range(3))
                        0, 1: v = pool[$urandom_range(5)];
                        2:    v = $urandom;
                        default: v = $urandom_range(1) ? VAL_MAX - $urandom_range(3)
                                                       : VAL_MIN + $urandom_range(3);
                    endcase
                    queue_sample(v, k == set_len - 1);
                end
            end
            made += set_len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_samples.size() > 0 || sample_ch.valid || expected_pairs.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        run_done = 1'b1;

        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("** sorted_value_frequency_table: PASSED **");
        else
            $display("** sorted_value_frequency_table: FAILED **");
        $finish;
    end

endmodule

[sim.f]
design/svft_pkg.sv
design/svft_if.sv
design/svft_cell.sv
design/sorted_value_frequency_table.sv
bench/sorted_value_frequency_table_tb.sv
